/* hw/rtl/dnswr_pkg.sv */
// Package for the DNS wildcard responder: beat types, constants and answer record table.
`timescale 1ns / 1ps

package dnswr_pkg;

    localparam int unsigned DEF_MAX_QUERY_BYTES = 512;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_ANSWER_ADDRESS = 1'b0;
    localparam logic REG_ANSWER_TTL     = 1'b1;

    localparam logic [31:0] RESET_ANSWER_ADDRESS = 32'hC0A8_0401;
    localparam logic [31:0] RESET_ANSWER_TTL     = 32'd60;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_TAIL   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [2:0] TAIL_BYTES = 3'd4;
    localparam logic [3:0] ANSWER_LAST_IDX = 4'd15;

    localparam logic [7:0] FLAGS_HI_REPLY = 8'h81;
    localparam logic [7:0] FLAGS_LO_REPLY = 8'h80;
    localparam logic [7:0] ANCOUNT_LO     = 8'h01;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       drop;
    } out_beat_t;

    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] ttl,
                                               input logic [31:0] addr);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'hC0;
            4'd1:    b = 8'h0C;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h01;
            4'd6:    b = ttl[31:24];
            4'd7:    b = ttl[23:16];
            4'd8:    b = ttl[15:8];
            4'd9:    b = ttl[7:0];
            4'd10:   b = 8'h00;
            4'd11:   b = 8'h04;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            default: b = addr[7:0];
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/dns_wildcard_responder.sv */
// Top level of the DNS wildcard responder: query parser, answer burst and APB registers.
// A reply beat is registered in the output register in the cycle after its query beat is taken.
// Throughput: one query beat per cycle while the output is not stalled; the beat that ends the
//   question adds a 16-beat answer burst from the answer counter, during which s_ready is low.
// Reset: aresetn (synchronous, active low) clears parser state and output valid and
//   loads answer_address 192.168.4.1 and answer_ttl 60.
`timescale 1ns / 1ps

module dns_wildcard_responder
    import dnswr_pkg::*;
#(
    parameter int unsigned MAX_QUERY_BYTES = DEF_MAX_QUERY_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_payload,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned POS_W = $clog2(MAX_QUERY_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_QUERY_BYTES);

    logic [31:0] answer_address_reg;
    logic [31:0] answer_ttl_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       label_rem_reg, label_rem_next;
    logic [2:0]       tail_rem_reg, tail_rem_next;
    logic             resp_seen_reg, resp_seen_next;

    logic       burst_reg, burst_next;
    logic [3:0] ans_idx_reg, ans_idx_next;
    logic       burst_last_reg, burst_last_next;
    logic       burst_drop_reg, burst_drop_next;

    logic      m_valid_reg, m_valid_next;
    out_beat_t m_payload_reg, m_payload_next;

    logic       out_free;
    logic       in_fire;
    logic       cfg_write;
    logic       emit;
    logic       trigger;
    logic [7:0] o_byte;
    logic [7:0] b;
    logic       drop_now;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == REG_ANSWER_TTL) ? answer_ttl_reg : answer_address_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !burst_reg && out_free;
    assign in_fire   = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign b         = s_payload.in_byte;

    always_comb begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        label_rem_next = label_rem_reg;
        tail_rem_next  = tail_rem_reg;
        resp_seen_next = resp_seen_reg;
        emit           = 1'b0;
        trigger        = 1'b0;
        o_byte         = b;

        if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg)
                PH_HEADER: begin
                    emit = 1'b1;
                    if (pos_reg == POS_W'(2)) begin
                        resp_seen_next = resp_seen_reg | b[7];
                        o_byte = FLAGS_HI_REPLY;
                    end else if (pos_reg == POS_W'(3)) begin
                        o_byte = FLAGS_LO_REPLY;
                    end else if (pos_reg == POS_W'(7)) begin
                        o_byte = ANCOUNT_LO;
                    end else if (pos_reg == POS_W'(6) || pos_reg >= POS_W'(8)) begin
                        o_byte = 8'h00;
                    end
                    if (pos_reg >= POS_W'(11)) begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    emit = 1'b1;
                    if (b == 8'h00) begin
                        phase_next    = PH_TAIL;
                        tail_rem_next = TAIL_BYTES;
                    end else begin
                        phase_next     = PH_LABEL;
                        label_rem_next = b;
                    end
                end
                PH_LABEL: begin
                    emit = 1'b1;
                    if (label_rem_reg > 8'd1) begin
                        label_rem_next = label_rem_reg - 1'b1;
                    end else begin
                        label_rem_next = 8'd0;
                        phase_next     = PH_LENGTH;
                    end
                end
                PH_TAIL: begin
                    emit = 1'b1;
                    if (tail_rem_reg > 3'd1) begin
                        tail_rem_next = tail_rem_reg - 1'b1;
                    end else begin
                        tail_rem_next = 3'd0;
                        phase_next    = PH_DONE;
                        trigger       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        drop_now = (phase_next != PH_DONE) || resp_seen_next;
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_payload_next  = m_payload_reg;
        burst_next      = burst_reg;
        ans_idx_next    = ans_idx_reg;
        burst_last_next = burst_last_reg;
        burst_drop_next = burst_drop_reg;

        if (out_free) begin
            m_valid_next = 1'b0;
        end

        if (burst_reg && out_free) begin
            m_valid_next              = 1'b1;
            m_payload_next.out_byte   = answer_byte(ans_idx_reg, answer_ttl_reg,
                                                    answer_address_reg);
            m_payload_next.byte_valid = 1'b1;
            m_payload_next.last       = 1'b0;
            m_payload_next.drop       = 1'b0;
            ans_idx_next              = ans_idx_reg + 1'b1;
            if (ans_idx_reg == ANSWER_LAST_IDX) begin
                burst_next          = 1'b0;
                m_payload_next.last = burst_last_reg;
                m_payload_next.drop = burst_last_reg & burst_drop_reg;
            end
        end else if (in_fire) begin
            if (emit || s_payload.in_last) begin
                m_valid_next              = 1'b1;
                m_payload_next.out_byte   = emit ? o_byte : 8'h00;
                m_payload_next.byte_valid = emit;
                m_payload_next.last       = s_payload.in_last & !trigger;
                m_payload_next.drop       = s_payload.in_last & !trigger & drop_now;
            end
            if (trigger) begin
                burst_next      = 1'b1;
                ans_idx_next    = 4'd0;
                burst_last_next = s_payload.in_last;
                burst_drop_next = resp_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            answer_address_reg <= RESET_ANSWER_ADDRESS;
            answer_ttl_reg     <= RESET_ANSWER_TTL;
        end else if (cfg_write) begin
            if (paddr[2] == REG_ANSWER_TTL) begin
                answer_ttl_reg <= pwdata;
            end else begin
                answer_address_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            phase_reg     <= PH_HEADER;
            label_rem_reg <= '0;
            tail_rem_reg  <= '0;
            resp_seen_reg <= 1'b0;
        end else if (in_fire) begin
            if (s_payload.in_last) begin
                pos_reg       <= '0;
                phase_reg     <= PH_HEADER;
                label_rem_reg <= '0;
                tail_rem_reg  <= '0;
                resp_seen_reg <= 1'b0;
            end else begin
                pos_reg       <= pos_next;
                phase_reg     <= phase_next;
                label_rem_reg <= label_rem_next;
                tail_rem_reg  <= tail_rem_next;
                resp_seen_reg <= resp_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            burst_reg   <= 1'b0;
            ans_idx_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            burst_reg   <= burst_next;
            ans_idx_reg <= ans_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg  <= m_payload_next;
        burst_last_reg <= burst_last_next;
        burst_drop_reg <= burst_drop_next;
    end

endmodule

/* test/tb_dns_wildcard_responder.sv */
// Testbench for the DNS wildcard responder: query streams, reply beat checks and APB setup.
`timescale 1ns / 1ps

module tb_dns_wildcard_responder;
    import dnswr_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_ANSWER_ADDRESS = {REG_ANSWER_ADDRESS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_ANSWER_TTL     = {REG_ANSWER_TTL, 2'b00};

    class dns_reply_scoreboard;
        out_beat_t   reply_q[$];
        logic [31:0] answer_addr;
        logic [31:0] answer_ttl;
        logic [9:0]  pos;
        logic [2:0]  phase;
        logic [7:0]  label_left;
        logic [2:0]  tail_left;
        logic        qr_seen;
        int          failures;
        int          checked;
        int          packets;
        int          answers;
        int          dropped;

        function new();
            answer_addr = RESET_ANSWER_ADDRESS;
            answer_ttl  = RESET_ANSWER_TTL;
            clear_packet();
        endfunction

        function void clear_packet();
            pos        = '0;
            phase      = PH_HEADER;
            label_left = '0;
            tail_left  = '0;
            qr_seen    = 1'b0;
        endfunction

        function void push_reply(logic [7:0] b, logic v);
            out_beat_t r;
            r.out_byte   = b;
            r.byte_valid = v;
            r.last       = 1'b0;
            r.drop       = 1'b0;
            reply_q.push_back(r);
        endfunction

        function string beat_str(out_beat_t r);
            return $sformatf("byte=%02h valid=%0b last=%0b drop=%0b",
                             r.out_byte, r.byte_valid, r.last, r.drop);
        endfunction

        function void report(string what);
            if (failures < 10)
                $display("MISMATCH at %0t: %s", $realtime, what);
            failures++;
        endfunction

        function int pending();
            return reply_q.size();
        endfunction

        function void note_query_beat(in_beat_t beat);
            logic [7:0]   b;
            logic [7:0]   o;
            logic [9:0]   p;
            logic [127:0] rec;
            int           n_before;
            logic         drop;
            out_beat_t    end_beat;
            b        = beat.in_byte;
            n_before = reply_q.size();
            if (pos < DEF_MAX_QUERY_BYTES) begin
                p   = pos;
                pos = pos + 10'd1;
                case (phase)
                    PH_HEADER: begin
                        o = b;
                        if (p == 10'd2) begin
                            if (b[7])
                                qr_seen = 1'b1;
                            o = FLAGS_HI_REPLY;
                        end else if (p == 10'd3) begin
                            o = FLAGS_LO_REPLY;
                        end else if (p == 10'd7) begin
                            o = ANCOUNT_LO;
                        end else if (p == 10'd6 || p >= 10'd8) begin
                            o = 8'h00;
                        end
                        push_reply(o, 1'b1);
                        if (p >= 10'd11)
                            phase = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        push_reply(b, 1'b1);
                        if (b == 8'h00) begin
                            phase     = PH_TAIL;
                            tail_left = TAIL_BYTES;
                        end else begin
                            phase      = PH_LABEL;
                            label_left = b;
                        end
                    end
                    PH_LABEL: begin
                        push_reply(b, 1'b1);
                        if (label_left != 8'd0)
                            label_left = label_left - 8'd1;
                        if (label_left == 8'd0)
                            phase = PH_LENGTH;
                    end
                    PH_TAIL: begin
                        push_reply(b, 1'b1);
                        if (tail_left != 3'd0)
                            tail_left = tail_left - 3'd1;
                        if (tail_left == 3'd0) begin
                            phase = PH_DONE;
                            rec = {8'hC0, 8'h0C, 16'h0001, 16'h0001, answer_ttl,
                                   16'h0004, answer_addr};
                            for (int i = 15; i >= 0; i--)
                                push_reply(rec[i*8 +: 8], 1'b1);
                            answers++;
                        end
                    end
                    default: ;
                endcase
            end
            if (beat.in_last) begin
                drop = (phase != PH_DONE) || qr_seen;
                if (reply_q.size() == n_before)
                    push_reply(8'h00, 1'b0);
                end_beat      = reply_q[reply_q.size() - 1];
                end_beat.last = 1'b1;
                end_beat.drop = drop;
                reply_q[reply_q.size() - 1] = end_beat;
                packets++;
                if (drop)
                    dropped++;
                clear_packet();
            end
        endfunction

        function void check_reply_beat(out_beat_t got);
            out_beat_t want;
            if (reply_q.size() == 0) begin
                report({"reply beat with nothing expected: ", beat_str(got)});
                return;
            end
            want = reply_q.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.last !== want.last || got.drop !== want.drop)
                report($sformatf("reply beat %0d: expected %s, got %s",
                                 checked, beat_str(want), beat_str(got)));
        endfunction

        function void flush_leftovers();
            if (reply_q.size() != 0) begin
                report($sformatf("%0d reply beats never arrived, first %s",
                                 reply_q.size(), beat_str(reply_q[0])));
                failures += reply_q.size() - 1;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_beat_t              s_payload = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_payload;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dns_reply_scoreboard sb;
    logic [7:0]          pkt[$];
    int                  idle_pct = 9;
    bit                  long_hold = 1'b0;
    int                  sent_beats = 0;
    int                  settings = 1;

    dns_wildcard_responder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && sb != null) begin
            if (s_valid && s_ready)
                sb.note_query_beat(s_payload);
            if (m_valid && m_ready)
                sb.check_reply_beat(m_payload);
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (150) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin
        #2400000;
        $display("tb_dns_wildcard_responder: done, errors");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{in_byte: b, in_last: l};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pkt();
        foreach (pkt[i])
            send_beat(pkt[i], i == pkt.size() - 1);
        sent_beats += pkt.size();
        pkt.delete();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic [APB_ADDR_W-1:0] a, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== want)
            sb.report($sformatf("register at %0d: expected %08h, got %08h", a, want, got));
    endtask

    task automatic set_answer(input logic [31:0] addr, input logic [31:0] ttl);
        apb_write(ADDR_ANSWER_ADDRESS, addr);
        apb_write(ADDR_ANSWER_TTL, ttl);
        sb.answer_addr = addr;
        sb.answer_ttl  = ttl;
        check_reg(ADDR_ANSWER_ADDRESS, addr);
        check_reg(ADDR_ANSWER_TTL, ttl);
        settings++;
    endtask

    task automatic add_header(input bit qr);
        logic [7:0] b;
        for (int i = 0; i < 12; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i == 2)
                b[7] = qr;
            pkt.push_back(b);
        end
    endtask

    task automatic add_question(input int n_labels, input int max_len);
        int len;
        repeat (n_labels) begin
            len = $urandom_range(1, max_len);
            pkt.push_back(len[7:0]);
            repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
        end
        pkt.push_back(8'h00);
        repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_packet();
        int kind;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            add_header($urandom_range(0, 9) == 0);
            add_question($urandom_range(1, 3), 8);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom_range(0, 255)));
            // truncate some well-formed packets anywhere
            if (kind >= 68) begin
                cut = $urandom_range(1, pkt.size() - 1);
                pkt = pkt[0:cut-1];
            end
        end else if (kind < 94) begin
            repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_header(1'b0);
            pkt.push_back(8'hC0);
            pkt.push_back(8'h0C);
            repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int beats);
        int start;
        start = sent_beats;
        while (sent_beats - start < beats) begin
            add_random_packet();
            send_pkt();
        end
    endtask

    task automatic run_directed();
        // one-byte packet, then an 11-byte one: both too short
        pkt.push_back(8'hFF);
        send_pkt();
        repeat (11) pkt.push_back(8'h00);
        send_pkt();
        // all-ones header but for the QR bit, root name, all-ones tail
        for (int i = 0; i < 12; i++)
            pkt.push_back(i == 2 ? 8'h7F : 8'hFF);
        pkt.push_back(8'h00);
        repeat (4) pkt.push_back(8'hFF);
        send_pkt();
        // all-zero header, one short label
        repeat (12) pkt.push_back(8'h00);
        pkt.push_back(8'h03);
        pkt.push_back(8'h61);
        pkt.push_back(8'h62);
        pkt.push_back(8'h63);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        send_pkt();
        // response bit set
        add_header(1'b1);
        add_question(2, 6);
        send_pkt();
        // end in the middle of a label
        add_header(1'b0);
        pkt.push_back(8'h05);
        pkt.push_back(8'h41);
        pkt.push_back(8'h42);
        send_pkt();
        // end inside qtype/qclass
        add_header(1'b0);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        send_pkt();
        // end right after the header
        add_header(1'b0);
        send_pkt();
        // compression pointer walked as a length
        add_header(1'b0);
        pkt.push_back(8'hC0);
        pkt.push_back(8'h0C);
        send_pkt();
        // trailing bytes after the question
        add_header(1'b0);
        add_question(1, 4);
        repeat (3) pkt.push_back(8'($urandom_range(0, 255)));
        send_pkt();
        // past the size limit, answered early
        add_header(1'b0);
        add_question(1, 8);
        while (pkt.size() < 530) pkt.push_back(8'($urandom_range(0, 255)));
        send_pkt();
        // past the size limit, question never ends
        add_header(1'b0);
        while (pkt.size() < 530) begin
            pkt.push_back(8'hFF);
            repeat (255) pkt.push_back(8'($urandom_range(0, 255)));
        end
        pkt = pkt[0:529];
        send_pkt();
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_reg(ADDR_ANSWER_ADDRESS, RESET_ANSWER_ADDRESS);
        check_reg(ADDR_ANSWER_TTL, RESET_ANSWER_TTL);
        run_directed();
        drain();

        set_answer(32'hFFFF_FFFF, 32'h0000_0000);
        run_random(80);
        drain();

        // no idling on either side
        set_answer(32'h0000_0000, 32'hFFFF_FFFF);
        idle_pct = 0;
        run_random(80);
        drain();
        idle_pct = 9;

        // long receiver hold-off while queries keep coming
        set_answer($urandom(), $urandom());
        long_hold = 1'b1;
        run_random(80);
        drain();

        set_answer($urandom(), $urandom_range(0, 86400));
        run_random(70);
        drain();
        repeat (8) @(posedge aclk);

        sb.flush_leftovers();
        $display("covered %0d query beats in %0d packets: %0d answered, %0d dropped",
                 sent_beats, sb.packets, sb.answers, sb.dropped);
        $display("checked %0d reply beats across %0d answer settings, %0d mismatches",
                 sb.checked, settings, sb.failures);
        if (sb.failures == 0)
            $display("tb_dns_wildcard_responder: done, clean");
        else
            $display("tb_dns_wildcard_responder: done, errors");
        $finish;
    end

endmodule
